@@ rtl/core/rrts_pkg.sv @@
// Shared types and codes for the round-robin thread scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

   localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_SPAWN  = 3'd1;
   localparam logic [2:0] OP_TERM   = 3'd2;
   localparam logic [2:0] OP_BLOCK  = 3'd3;
   localparam logic [2:0] OP_RESUME = 3'd4;
   localparam logic [2:0] OP_SLEEP  = 3'd5;

   localparam logic [2:0] STS_OK         = 3'd0;
   localparam logic [2:0] STS_BAD_ID     = 3'd1;
   localparam logic [2:0] STS_NO_SLOT    = 3'd2;
   localparam logic [2:0] STS_MAIN_TERM  = 3'd3;
   localparam logic [2:0] STS_MAIN_SLEEP = 3'd4;

   localparam logic [1:0] SL_UNUSED  = 2'd0;
   localparam logic [1:0] SL_READY   = 2'd1;
   localparam logic [1:0] SL_RUNNING = 2'd2;
   localparam logic [1:0] SL_BLOCKED = 2'd3;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  thread_id;
      logic [30:0] sleep_quanta;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  new_thread_id;
      logic [7:0]  running_id;
      logic        switched;
      logic [30:0] total_count;
      logic        queue_overflow;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  st;
      logic [30:0] qn;
      logic [30:0] dl;
   } slot_entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_OP_RD, S_OP_EX, S_SP_RD, S_SP_CK, S_WK_RD, S_WK_CK,
      S_PR_RING, S_PR_SLOT, S_PR_CK, S_PV_RD, S_PV_CK, S_FINISH
   } state_type;

endpackage

@@ rtl/core/rrts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/rrts_slot_table.sv @@
// Thread slot table: RAM plus per-slot valid bits that stand in for the reset contents.
`timescale 1ns / 1ps

module rrts_slot_table import rrts_pkg::*; #(
   parameter int THREAD_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(THREAD_SLOTS)-1:0] rd_addr,
   input  logic                            wr_en,
   input  logic [$clog2(THREAD_SLOTS)-1:0] wr_addr,
   input  slot_entry_type                  wr_data,
   output slot_entry_type                  rd_entry
);

   localparam int IDW = $clog2(THREAD_SLOTS);

   logic [THREAD_SLOTS-1:0] vld_ff;
   logic [IDW-1:0]          rd_addr_ff;
   logic [$bits(slot_entry_type)-1:0] ram_rdata;
   slot_entry_type          rst_entry;

   rrts_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (THREAD_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
      rd_addr_ff <= rd_addr;
   end

   // unwritten slots read as their reset value: slot zero running with one quantum
   always_comb begin
      rst_entry.st = (rd_addr_ff == '0) ? SL_RUNNING : SL_UNUSED;
      rst_entry.qn = (rd_addr_ff == '0) ? 31'd1 : 31'd0;
      rst_entry.dl = 31'd0;
      rd_entry = vld_ff[rd_addr_ff] ? slot_entry_type'(ram_rdata) : rst_entry;
   end

endmodule

@@ rtl/core/round_robin_thread_scheduler_top.sv @@
// Top level of the round-robin thread scheduler with sleep.
`timescale 1ns / 1ps

// One command is taken at a time and answered by one word. A sequencer walks the
// slot table through a slot RAM with one read port, so the cost is set by that RAM
// port: tick, sleep and blocking or terminating the current thread run a wake pass
// over slots 1..THREAD_SLOTS-1, then pop ring entries until a ready one is found
// (at most one lap of stale entries) and hand back the previous thread. Spawn
// scans slots 1..THREAD_SLOTS-1 for a free slot; resume and the other forms of
// block and terminate read one slot and answer. A new command is taken while the
// last answer still waits in the output register.

module round_robin_thread_scheduler_top import rrts_pkg::*; #(
   parameter int THREAD_SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   localparam int IDW = $clog2(THREAD_SLOTS);
   localparam logic [IDW-1:0] LAST = IDW'(THREAD_SLOTS - 1);

   state_type      state_ff, state_in;
   logic [2:0]     op_ff, op_in;
   logic [7:0]     id_ff, id_in;
   logic [30:0]    q_ff, q_in;
   logic [IDW-1:0] cur_ff, cur_in;
   logic [IDW-1:0] before_ff, before_in;
   logic [30:0]    total_ff, total_in;
   logic [IDW-1:0] head_ff, head_in;
   logic [IDW-1:0] tail_ff, tail_in;
   logic [IDW-1:0] start_ff, start_in;
   logic [IDW-1:0] idx_ff, idx_in;
   logic [IDW-1:0] t_ff, t_in;
   logic [IDW-1:0] prev_ff, prev_in;
   logic [2:0]     status_ff, status_in;
   logic [IDW-1:0] newid_ff, newid_in;
   logic           drop_ff, drop_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [IDW-1:0] slot_raddr, slot_waddr;
   logic           slot_we;
   slot_entry_type slot_wdata, e;
   logic           ring_we;
   logic [IDW-1:0] ring_rdata;
   logic           push_en;
   logic [IDW-1:0] push_id;
   logic           oor;
   logic [IDW-1:0] tgt;
   logic [31:0]    dl_sum;

   function automatic logic [IDW-1:0] wrap_inc(input logic [IDW-1:0] x);
      return (x == LAST) ? '0 : x + 1'b1;
   endfunction

   rrts_slot_table #(.THREAD_SLOTS(THREAD_SLOTS)) u_slots (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (slot_raddr),
      .wr_en    (slot_we),
      .wr_addr  (slot_waddr),
      .wr_data  (slot_wdata),
      .rd_entry (e)
   );

   rrts_ram #(.WIDTH(IDW), .DEPTH(THREAD_SLOTS)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (tail_ff),
      .wr_data (push_id),
      .rd_addr (head_ff),
      .rd_data (ring_rdata)
   );

   assign oor    = {1'b0, id_ff} >= 9'(THREAD_SLOTS);
   assign tgt    = id_ff[IDW-1:0];
   assign dl_sum = {1'b0, total_ff} + {1'b0, q_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         total_ff     <= 31'd1;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         total_ff     <= total_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      id_ff     <= id_in;
      q_ff      <= q_in;
      before_ff <= before_in;
      start_ff  <= start_in;
      idx_ff    <= idx_in;
      t_ff      <= t_in;
      prev_ff   <= prev_in;
      status_ff <= status_in;
      newid_ff  <= newid_in;
      drop_ff   <= drop_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      q_in         = q_ff;
      cur_in       = cur_ff;
      before_in    = before_ff;
      total_in     = total_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      start_in     = start_ff;
      idx_in       = idx_ff;
      t_in         = t_ff;
      prev_in      = prev_ff;
      status_in    = status_ff;
      newid_in     = newid_ff;
      drop_in      = drop_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      slot_raddr   = '0;
      slot_we      = 1'b0;
      slot_waddr   = '0;
      slot_wdata   = e;
      push_en      = 1'b0;
      push_id      = '0;
      ring_we      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req.opcode;
               id_in     = req.thread_id;
               q_in      = req.sleep_quanta;
               before_in = cur_ff;
               status_in = STS_OK;
               newid_in  = '0;
               drop_in   = 1'b0;
               idx_in    = IDW'(1);
               if (req.opcode == OP_SPAWN) begin
                  state_in = S_SP_RD;
               end else if (req.opcode > OP_SLEEP) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_OP_RD;
               end
            end
         end
         S_OP_RD: begin
            slot_raddr = (op_ff == OP_TICK || op_ff == OP_SLEEP) ? cur_ff : tgt;
            state_in   = S_OP_EX;
         end
         S_OP_EX: begin
            start_in = head_ff;
            prev_in  = cur_ff;
            idx_in   = IDW'(1);
            state_in = S_FINISH;
            unique case (op_ff)
               OP_TICK: begin
                  total_in      = (total_ff == SAT31) ? total_ff : total_ff + 31'd1;
                  slot_we       = 1'b1;
                  slot_waddr    = cur_ff;
                  slot_wdata.qn = (e.qn == SAT31) ? e.qn : e.qn + 31'd1;
                  state_in      = S_WK_RD;
               end
               OP_TERM: begin
                  if (oor || e.st == SL_UNUSED) begin
                     status_in = STS_BAD_ID;
                  end else if (id_ff == 8'd0) begin
                     status_in = STS_MAIN_TERM;
                  end else begin
                     slot_we       = 1'b1;
                     slot_waddr    = tgt;
                     slot_wdata.st = SL_UNUSED;
                     if (e.st == SL_RUNNING && tgt == cur_ff) begin
                        state_in = S_WK_RD;
                     end
                  end
               end
               OP_BLOCK: begin
                  if (id_ff == 8'd0 || oor || e.st == SL_UNUSED) begin
                     status_in = STS_BAD_ID;
                  end else if (e.st != SL_BLOCKED) begin
                     slot_we       = 1'b1;
                     slot_waddr    = tgt;
                     slot_wdata.st = SL_BLOCKED;
                     if (tgt == cur_ff) begin
                        state_in = S_WK_RD;
                     end
                  end
               end
               OP_RESUME: begin
                  if (oor || e.st == SL_UNUSED) begin
                     status_in = STS_BAD_ID;
                  end else if (e.st == SL_BLOCKED) begin
                     slot_we       = 1'b1;
                     slot_waddr    = tgt;
                     slot_wdata.st = SL_READY;
                     push_en       = 1'b1;
                     push_id       = tgt;
                  end
               end
               OP_SLEEP: begin
                  if (cur_ff == '0) begin
                     status_in = STS_MAIN_SLEEP;
                  end else begin
                     slot_we       = 1'b1;
                     slot_waddr    = cur_ff;
                     slot_wdata.st = SL_BLOCKED;
                     slot_wdata.dl = dl_sum[31] ? SAT31 : dl_sum[30:0];
                     state_in      = S_WK_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SP_RD: begin
            slot_raddr = idx_ff;
            state_in   = S_SP_CK;
         end
         S_SP_CK: begin
            if (e.st == SL_UNUSED) begin
               slot_we    = 1'b1;
               slot_waddr = idx_ff;
               slot_wdata = '{st: SL_READY, qn: 31'd0, dl: 31'd0};
               push_en    = 1'b1;
               push_id    = idx_ff;
               newid_in   = idx_ff;
               state_in   = S_FINISH;
            end else if (idx_ff == LAST) begin
               status_in = STS_NO_SLOT;
               state_in  = S_FINISH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SP_RD;
            end
         end
         S_WK_RD: begin
            slot_raddr = idx_ff;
            state_in   = S_WK_CK;
         end
         S_WK_CK: begin
            if (e.st == SL_BLOCKED && e.dl != 31'd0 && e.dl <= total_ff) begin
               slot_we       = 1'b1;
               slot_waddr    = idx_ff;
               slot_wdata.st = SL_READY;
               slot_wdata.dl = 31'd0;
               push_en       = 1'b1;
               push_id       = idx_ff;
            end
            if (idx_ff == LAST) begin
               idx_in   = '0;
               state_in = S_PR_RING;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_WK_RD;
            end
         end
         S_PR_RING: begin
            // ring read of the head entry is always in flight
            state_in = (head_ff == tail_ff) ? S_FINISH : S_PR_SLOT;
         end
         S_PR_SLOT: begin
            t_in       = ring_rdata;
            head_in    = wrap_inc(head_ff);
            slot_raddr = ring_rdata;
            state_in   = S_PR_CK;
         end
         S_PR_CK: begin
            if (e.st == SL_READY) begin
               slot_we       = 1'b1;
               slot_waddr    = t_ff;
               slot_wdata.st = SL_RUNNING;
               cur_in        = t_ff;
               state_in      = S_PV_RD;
            end else begin
               push_en = 1'b1;
               push_id = t_ff;
               if (head_ff == start_ff || idx_ff == LAST) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_PR_RING;
               end
            end
         end
         S_PV_RD: begin
            slot_raddr = prev_ff;
            state_in   = S_PV_CK;
         end
         S_PV_CK: begin
            if (e.st == SL_RUNNING) begin
               slot_we       = 1'b1;
               slot_waddr    = prev_ff;
               slot_wdata.st = SL_READY;
               push_en       = 1'b1;
               push_id       = prev_ff;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status         = status_in;
               rsp_in.new_thread_id  = 8'(newid_ff);
               rsp_in.running_id     = 8'(cur_ff);
               rsp_in.switched       = cur_ff != before_ff;
               rsp_in.total_count    = total_ff;
               rsp_in.queue_overflow = drop_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // shared ring append: drop when one more entry would meet the head
      if (push_en) begin
         if (wrap_inc(tail_ff) == head_in) begin
            drop_in = 1'b1;
         end else begin
            ring_we = 1'b1;
            tail_in = wrap_inc(tail_ff);
         end
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ rtl/core/rrts_checker.sv @@
// Port-level checks for the thread scheduler, bound to the top level.
`timescale 1ns / 1ps

module rrts_checker import rrts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   // a stalled answer word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("answer word dropped while stalled");

   // a stalled command word stays up and unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req))
      else $error("command word changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.status <= STS_MAIN_SLEEP)
      else $error("status code out of range");

   // failed commands never change the running thread
   a_fail_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != STS_OK |-> !rsp.switched)
      else $error("switch on a failed command");

   // a new id comes only with an OK status and never with a switch
   a_newid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.new_thread_id != 8'd0 |-> rsp.status == STS_OK && !rsp.switched)
      else $error("new id with bad status or switch");

endmodule

bind round_robin_thread_scheduler_top rrts_checker u_rrts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
